/* rtl/core/bmp_24bit_stream_parser_assert.svh */
// Assertion macros shared by the BMP stream parser RTL.
`ifndef BMP_24BIT_STREAM_PARSER_ASSERT_SVH
`define BMP_24BIT_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp parser: assertion failed");
// Next-cycle implication, disabled during reset.
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp parser: assertion failed");
`else
`define BMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/bmp_pkg.sv */
// Types, constants and result builders for the BMP stream parser.
`default_nettype none
package bmp_pkg;

    localparam int COORD_BITS  = 17;
    localparam int HEADER_LEN  = 54;
    localparam int POS_WIDTH   = 18;
    localparam int POS_HEIGHT  = 22;
    localparam int POS_DEPTH   = 28;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;

    localparam logic [7:0]  SIG_B       = 8'h42;
    localparam logic [7:0]  SIG_M       = 8'h4D;
    localparam logic [15:0] DEPTH_24    = 16'd24;
    localparam logic [COORD_BITS-1:0] LIMIT_RESET = COORD_BITS'(100000);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_DRAIN  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SIGNATURE = 2'd1,
        ERR_DIMS      = 2'd2,
        ERR_TRUNC     = 2'd3
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] image_width;
        logic [COORD_BITS-1:0] image_height;
        t_err                  error_code;
    } t_result;

    function automatic t_result f_error(input t_err code);
        t_result res;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = code;
        return res;
    endfunction

    function automatic t_result f_done();
        t_result res;
        res      = '0;
        res.kind = KIND_DONE;
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bmp_res_fifo.sv */
// Result queue: up to two results written per cycle, one read per cycle while i_ready is high.
`default_nettype none
`include "bmp_24bit_stream_parser_assert.svh"
module bmp_res_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr0,
    input  wire               i_wr1,
    input  bmp_pkg::t_result  i_data0,
    input  bmp_pkg::t_result  i_data1,
    output logic              o_room2,
    output logic              o_valid,
    input  wire               i_ready,
    output bmp_pkg::t_result  o_data
);
    import bmp_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, n_wptr;
    logic [FIFO_AW-1:0]   r_rptr, n_rptr;
    logic [FIFO_AW:0]     r_count, n_count;
    logic                 w_pop;
    logic [FIFO_AW:0]     w_push_n;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rptr];
    assign o_room2  = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign w_pop    = o_valid && i_ready;
    assign w_push_n = (FIFO_AW+1)'(i_wr0) + (FIFO_AW+1)'(i_wr1);

    always_comb begin
        n_wptr  = r_wptr + FIFO_AW'(w_push_n);
        n_rptr  = r_rptr + FIFO_AW'(w_pop);
        n_count = r_count + w_push_n - (FIFO_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_wr1) begin
            r_mem[r_wptr + FIFO_AW'(1)] <= i_data1;
        end
    end

    `BMP_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    `BMP_ASSERT_NOW(a_wr_order, i_clk, i_rst_n, i_wr1, i_wr0)
    `BMP_ASSERT_NEXT(a_hold_count, i_clk, i_rst_n, !w_pop && !i_wr0, r_count == $past(r_count))

endmodule
`default_nettype wire

/* rtl/core/bmp_24bit_stream_parser.sv */
// Top level of the 24-bit uncompressed BMP byte stream parser.
// Usage:
//   Input channel: one file byte per beat (i_data_byte), i_last_byte marks the
//   final byte of a file. A beat is taken when i_valid and o_ready are high.
//   Output channel: one result per beat (o_kind and payload fields), taken when
//   o_valid and i_ready are high. Kinds: header accepted, pixel, error, done.
//   Config: i_cfg_we writes i_cfg_data into the dimension limit; write it only
//   while the block is idle. Reset value is 100000.
// Timing:
//   Each byte is decoded by one pass of logic into a 4-entry result queue, so
//   each result is registered in the queue before it reaches the output. Bytes
//   are taken at one per cycle while o_ready is high; a byte may push up to two
//   results (pixel or header followed by truncation or completion), and o_ready
//   holds high while the queue has room for two, which keeps one byte per cycle
//   when the output drains one result per cycle.
// Reset: synchronous, active low; clears the queue and returns the parser to
//   wait for the first byte of a file; the limit returns to 100000.
// Stall: when i_ready stays low the queue fills and o_ready drops; results
//   wait in order, none are lost.
`default_nettype none
`include "bmp_24bit_stream_parser_assert.svh"
module bmp_24bit_stream_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [bmp_pkg::COORD_BITS-1:0] i_cfg_data,
    // byte input channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    // result output channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [bmp_pkg::COORD_BITS-1:0] o_column,
    output logic [bmp_pkg::COORD_BITS-1:0] o_row,
    output logic [bmp_pkg::COORD_BITS-1:0] o_image_width,
    output logic [bmp_pkg::COORD_BITS-1:0] o_image_height,
    output logic [1:0]  o_error_code
);
    import bmp_pkg::*;

    // parser state
    logic [COORD_BITS-1:0] r_limit;
    t_phase                r_phase, n_phase;
    logic [5:0]            r_pos, n_pos;
    logic [31:0]           r_width, n_width;
    logic [31:0]           r_height, n_height;
    logic [15:0]           r_depth, n_depth;
    logic                  r_first_b, n_first_b;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_column, n_column;
    logic [1:0]            r_bip, n_bip;
    logic [1:0]            r_pad, n_pad;
    logic [7:0]            r_blue, n_blue;
    logic [7:0]            r_green, n_green;

    // decode outputs into the queue
    logic                  w_accept;
    logic                  w_wr0, w_wr1;
    t_result               w_res0, w_res1;
    logic                  w_room2;
    t_result               w_out;
    logic                  w_row_end;
    logic                  w_dims_ok;
    logic [COORD_BITS-1:0] w_col_inc;
    logic [COORD_BITS-1:0] w_row_inc;

    assign o_ready  = w_room2;
    assign w_accept = i_valid && w_room2;

    // Width and height are signed 32-bit words that must lie in 1..limit.
    function automatic logic f_dim_ok(input logic [31:0] v, input logic [COORD_BITS-1:0] lim);
        return (v != '0) && (v[31:COORD_BITS] == '0) && (v[COORD_BITS-1:0] <= lim);
    endfunction

    assign w_dims_ok = f_dim_ok(r_width, r_limit) && f_dim_ok(r_height, r_limit)
                       && (r_depth == DEPTH_24);
    assign w_col_inc = r_column + COORD_BITS'(1);
    assign w_row_inc = r_row + COORD_BITS'(1);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_width   = r_width;
        n_height  = r_height;
        n_depth   = r_depth;
        n_first_b = r_first_b;
        n_row     = r_row;
        n_column  = r_column;
        n_bip     = r_bip;
        n_pad     = r_pad;
        n_blue    = r_blue;
        n_green   = r_green;
        w_wr0     = 1'b0;
        w_wr1     = 1'b0;
        w_res0    = '0;
        w_res1    = '0;
        w_row_end = 1'b0;

        if (w_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == 6'd0) begin
                        // start of a file: clear the collected header words
                        n_first_b = (i_data_byte == SIG_B);
                        n_width   = '0;
                        n_height  = '0;
                        n_depth   = '0;
                    end
                    if (r_pos == 6'd1 && !(r_first_b && i_data_byte == SIG_M)) begin
                        w_wr0  = 1'b1;
                        w_res0 = f_error(ERR_SIGNATURE);
                        if (i_last_byte) begin
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                        end else begin
                            n_phase = PH_DRAIN;
                        end
                    end else begin
                        // gather the little-endian header fields
                        if (r_pos >= 6'(POS_WIDTH) && r_pos < 6'(POS_WIDTH + 4)) begin
                            n_width[8*(2'(r_pos - 6'(POS_WIDTH))) +: 8] = i_data_byte;
                        end else if (r_pos >= 6'(POS_HEIGHT) && r_pos < 6'(POS_HEIGHT + 4)) begin
                            n_height[8*(2'(r_pos - 6'(POS_HEIGHT))) +: 8] = i_data_byte;
                        end else if (r_pos >= 6'(POS_DEPTH) && r_pos < 6'(POS_DEPTH + 2)) begin
                            n_depth[8*(1'(r_pos - 6'(POS_DEPTH))) +: 8] = i_data_byte;
                        end

                        if (r_pos >= 6'(HEADER_LEN - 1)) begin
                            if (w_dims_ok) begin
                                w_wr0               = 1'b1;
                                w_res0              = '0;
                                w_res0.kind         = KIND_HEADER;
                                w_res0.image_width  = r_width[COORD_BITS-1:0];
                                w_res0.image_height = r_height[COORD_BITS-1:0];
                                n_phase  = PH_PIXELS;
                                n_row    = '0;
                                n_column = '0;
                                n_bip    = '0;
                                n_pad    = '0;
                                if (i_last_byte) begin
                                    // header valid but the file stops here
                                    w_wr1   = 1'b1;
                                    w_res1  = f_error(ERR_TRUNC);
                                    n_phase = PH_HEADER;
                                    n_pos   = '0;
                                end
                            end else begin
                                w_wr0  = 1'b1;
                                w_res0 = f_error(ERR_DIMS);
                                if (i_last_byte) begin
                                    n_phase = PH_HEADER;
                                    n_pos   = '0;
                                end else begin
                                    n_phase = PH_DRAIN;
                                end
                            end
                        end else if (i_last_byte) begin
                            w_wr0   = 1'b1;
                            w_res0  = f_error(ERR_TRUNC);
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                        end else begin
                            n_pos = r_pos + 6'd1;
                        end
                    end
                end

                PH_PIXELS: begin
                    if (r_pad != 2'd0) begin
                        // drop a row padding byte
                        n_pad     = r_pad - 2'd1;
                        w_row_end = (r_pad == 2'd1);
                    end else if (r_bip == 2'd0 || r_bip == 2'd3) begin
                        n_blue = i_data_byte;
                        n_bip  = 2'd1;
                    end else if (r_bip == 2'd1) begin
                        n_green = i_data_byte;
                        n_bip   = 2'd2;
                    end else begin
                        w_wr0         = 1'b1;
                        w_res0        = '0;
                        w_res0.kind   = KIND_PIXEL;
                        w_res0.red    = i_data_byte;
                        w_res0.green  = r_green;
                        w_res0.blue   = r_blue;
                        w_res0.column = r_column;
                        w_res0.row    = r_row;
                        n_bip         = 2'd0;
                        if (w_col_inc >= r_width[COORD_BITS-1:0]) begin
                            // row ends; 3*width bytes pad up by width mod 4
                            n_column  = '0;
                            n_pad     = r_width[1:0];
                            w_row_end = (r_width[1:0] == 2'd0);
                        end else begin
                            n_column = w_col_inc;
                        end
                    end

                    if (w_row_end && w_row_inc >= r_height[COORD_BITS-1:0]) begin
                        n_row = w_row_inc;
                        if (w_wr0) begin
                            w_wr1  = 1'b1;
                            w_res1 = f_done();
                        end else begin
                            w_wr0  = 1'b1;
                            w_res0 = f_done();
                        end
                        if (i_last_byte) begin
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                        end else begin
                            n_phase = PH_DRAIN;
                        end
                    end else begin
                        if (w_row_end) begin
                            n_row = w_row_inc;
                        end
                        if (i_last_byte) begin
                            if (w_wr0) begin
                                w_wr1  = 1'b1;
                                w_res1 = f_error(ERR_TRUNC);
                            end else begin
                                w_wr0  = 1'b1;
                                w_res0 = f_error(ERR_TRUNC);
                            end
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                        end
                    end
                end

                PH_DRAIN: begin
                    // drop bytes until the end of the file
                    if (i_last_byte) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end
                end

                default: begin
                    n_phase = PH_HEADER;
                    n_pos   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_phase   <= PH_HEADER;
            r_pos     <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_depth   <= '0;
            r_first_b <= 1'b0;
            r_row     <= '0;
            r_column  <= '0;
            r_bip     <= '0;
            r_pad     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_width   <= n_width;
            r_height  <= n_height;
            r_depth   <= n_depth;
            r_first_b <= n_first_b;
            r_row     <= n_row;
            r_column  <= n_column;
            r_bip     <= n_bip;
            r_pad     <= n_pad;
        end
    end

    // held color bytes are payload: no reset
    always_ff @(posedge i_clk) begin
        r_blue  <= n_blue;
        r_green <= n_green;
    end

    bmp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (w_wr0),
        .i_wr1   (w_wr1),
        .i_data0 (w_res0),
        .i_data1 (w_res1),
        .o_room2 (w_room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_kind         = 2'(w_out.kind);
    assign o_red          = w_out.red;
    assign o_green        = w_out.green;
    assign o_blue         = w_out.blue;
    assign o_column       = w_out.column;
    assign o_row          = w_out.row;
    assign o_image_width  = w_out.image_width;
    assign o_image_height = w_out.image_height;
    assign o_error_code   = 2'(w_out.error_code);

    `BMP_ASSERT_NOW(a_col_in_row, i_clk, i_rst_n, r_phase == PH_PIXELS, r_column < r_width[COORD_BITS-1:0])
    `BMP_ASSERT_NOW(a_row_in_img, i_clk, i_rst_n, r_phase == PH_PIXELS, r_row < r_height[COORD_BITS-1:0])
    `BMP_ASSERT_NOW(a_pad_aligned, i_clk, i_rst_n, r_pad != 2'd0, r_bip == 2'd0)

endmodule
`default_nettype wire
